### hdl/ddes_pkg.sv
// Package for the drive enable sequencer: state encoding, control words,
// error codes, register map and the structs passed between modules.
// No dependencies.
package ddes_pkg;

    // Register map
    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned DATA_W      = 32;
    localparam logic        REG_TIMEOUT = 1'b0;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    // Control words sent to the drive
    localparam logic [7:0] CW_OFF         = 8'd0;
    localparam logic [7:0] CW_SHUTDOWN    = 8'd6;
    localparam logic [7:0] CW_SWITCH_ON   = 8'd7;
    localparam logic [7:0] CW_ENABLE_OP   = 8'd15;
    localparam logic [7:0] CW_FAULT_RESET = 8'd128;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_FAULT   = 2'd2;

    // External state codes
    localparam logic [2:0] CODE_IDLE    = 3'd0;
    localparam logic [2:0] CODE_STARTUP = 3'd1;
    localparam logic [2:0] CODE_SODIS   = 3'd2;
    localparam logic [2:0] CODE_READY   = 3'd3;
    localparam logic [2:0] CODE_SWON    = 3'd4;
    localparam logic [2:0] CODE_OPEN    = 3'd5;
    localparam logic [2:0] CODE_FAULT   = 3'd6;
    localparam logic [2:0] CODE_RESET   = 3'd7;

    // Wait counter saturates at its maximum
    localparam int unsigned CNT_W   = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Status word bit positions
    localparam int unsigned SW_READY = 0;
    localparam int unsigned SW_SWON  = 1;
    localparam int unsigned SW_OPEN  = 2;
    localparam int unsigned SW_FAULT = 3;
    localparam int unsigned SW_WARN  = 7;

    // Stream widths
    localparam int unsigned IN_W  = 24;
    localparam int unsigned OUT_W = 24;

    // Sequencer state, one-hot
    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_STARTUP = 8'b0000_0010,
        ST_SODIS   = 8'b0000_0100,
        ST_READY   = 8'b0000_1000,
        ST_SWON    = 8'b0001_0000,
        ST_OPEN    = 8'b0010_0000,
        ST_FAULT   = 8'b0100_0000,
        ST_RESET   = 8'b1000_0000
    } ddes_state_e_t;

    // One input beat
    typedef struct packed {
        logic [15:0] status_word;
        logic        master_ok;
        logic        enable_cmd;
        logic        error_reset;
    } ddes_in_t;

    // Persistent sequencer state
    typedef struct packed {
        ddes_state_e_t    state;
        logic [CNT_W-1:0] wait_cnt;
        logic [7:0]       last_ctrl;
        logic             warn_prev;
        logic             en_prev;
        logic             startup_done;
    } ddes_ctx_t;

    // One result beat
    typedef struct packed {
        logic [7:0] control_word;
        logic [2:0] state_code;
        logic       drive_enabled;
        logic       hw_ready;
        logic [1:0] error_code;
        logic       drop_enable;
        logic       warning_rise;
    } ddes_res_t;

    // Map the one-hot state to the external code
    function automatic logic [2:0] state_to_code(input ddes_state_e_t st);
        logic [2:0] code;
        case (st)
            ST_IDLE:    code = CODE_IDLE;
            ST_STARTUP: code = CODE_STARTUP;
            ST_SODIS:   code = CODE_SODIS;
            ST_READY:   code = CODE_READY;
            ST_SWON:    code = CODE_SWON;
            ST_OPEN:    code = CODE_OPEN;
            ST_FAULT:   code = CODE_FAULT;
            default:    code = CODE_RESET;
        endcase
        return code;
    endfunction

endpackage

### hdl/ddes_cfg.sv
// APB register block holding the timeout limit.
// Depends on ddes_pkg.
module ddes_cfg
    import ddes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [15:0]       timeout_cycles
);

    logic [15:0] timeout_reg;
    logic        wr_en;

    // Register index is the word address; low bits are ignored
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    // Read back
    always_comb
    begin
        if (paddr[2] == REG_TIMEOUT)
        begin
            prdata = {{(DATA_W-16){1'b0}}, timeout_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign timeout_cycles = timeout_reg;

endmodule

### hdl/ddes_step.sv
// Combinational next-state and result logic for one status word.
// Depends on ddes_pkg.
module ddes_step
    import ddes_pkg::*;
(
    input  ddes_in_t    in_beat,
    input  ddes_ctx_t   ctx,
    input  logic [15:0] timeout_cycles,
    output ddes_ctx_t   ctx_next,
    output ddes_res_t   res
);

    always_comb
    begin
        ddes_ctx_t c;
        logic      b_ready;
        logic      b_swon;
        logic      b_open;
        logic      b_fault;
        logic      b_warn;
        logic      en;
        logic      mok;
        logic [1:0] err;
        logic      drop;
        logic      wrise;

        c       = ctx;
        b_ready = in_beat.status_word[SW_READY];
        b_swon  = in_beat.status_word[SW_SWON];
        b_open  = in_beat.status_word[SW_OPEN];
        b_fault = in_beat.status_word[SW_FAULT];
        b_warn  = in_beat.status_word[SW_WARN];
        en      = in_beat.enable_cmd;
        mok     = in_beat.master_ok;
        err     = ERR_NONE;
        drop    = 1'b0;
        wrise   = 1'b0;

        // Error reset applies before anything else
        if (in_beat.error_reset && c.state == ST_FAULT)
        begin
            c.state    = ST_RESET;
            c.wait_cnt = '0;
        end

        if (c.wait_cnt > {1'b0, timeout_cycles})
        begin
            // Timeout: latch fault and hold everything else
            c.state = ST_FAULT;
            err     = ERR_TIMEOUT;
        end
        else
        begin
            if (c.wait_cnt != CNT_MAX)
            begin
                c.wait_cnt = c.wait_cnt + 1'b1;
            end

            // One-time fault clear at startup
            if (!c.startup_done)
            begin
                if (mok && c.state == ST_FAULT)
                begin
                    c.state    = ST_RESET;
                    c.wait_cnt = '0;
                end
                if (!b_fault && mok)
                begin
                    c.startup_done = 1'b1;
                    c.state        = ST_RESET;
                end
            end

            wrise       = b_warn && !c.warn_prev;
            c.warn_prev = b_warn;

            // Later checks in each state take priority
            case (c.state)
                ST_IDLE:
                begin
                    c.last_ctrl = CW_OFF;
                    c.wait_cnt  = '0;
                    if (en && !c.en_prev)
                    begin
                        c.state = ST_STARTUP;
                    end
                end
                ST_STARTUP:
                begin
                    c.last_ctrl = CW_FAULT_RESET;
                    c.wait_cnt  = '0;
                    c.state     = ST_SODIS;
                end
                ST_SODIS:
                begin
                    c.last_ctrl = CW_SHUTDOWN;
                    if (b_ready)
                    begin
                        c.wait_cnt = '0;
                        c.state    = ST_READY;
                    end
                    if (!en)
                    begin
                        c.state = ST_IDLE;
                    end
                end
                ST_READY:
                begin
                    c.last_ctrl = CW_SWITCH_ON;
                    if (b_fault)
                    begin
                        c.wait_cnt = '0;
                        c.state    = ST_FAULT;
                    end
                    if (b_swon)
                    begin
                        c.wait_cnt = '0;
                        c.state    = ST_SWON;
                    end
                    if (!en)
                    begin
                        c.state = ST_IDLE;
                    end
                end
                ST_SWON:
                begin
                    c.last_ctrl = CW_ENABLE_OP;
                    if (b_fault)
                    begin
                        c.wait_cnt = '0;
                        c.state    = ST_FAULT;
                    end
                    if (b_open)
                    begin
                        c.wait_cnt = '0;
                        c.state    = ST_OPEN;
                    end
                    if (!en)
                    begin
                        c.state = ST_IDLE;
                    end
                end
                ST_OPEN:
                begin
                    if (b_fault)
                    begin
                        c.state = ST_FAULT;
                    end
                    c.wait_cnt = '0;
                    if (!en)
                    begin
                        c.state = ST_IDLE;
                    end
                end
                ST_FAULT:
                begin
                    c.last_ctrl = CW_OFF;
                    c.wait_cnt  = '0;
                    en          = 1'b0;
                    drop        = 1'b1;
                    err         = ERR_FAULT;
                end
                default:
                begin
                    // Reset state: send fault reset until the fault bit clears
                    c.last_ctrl = CW_FAULT_RESET;
                    c.wait_cnt  = '0;
                    if (!b_fault)
                    begin
                        c.state = ST_IDLE;
                        drop    = 1'b1;
                    end
                end
            endcase
            c.en_prev = en;
        end

        ctx_next          = c;
        res.control_word  = c.last_ctrl;
        res.state_code    = state_to_code(c.state);
        res.drive_enabled = b_open;
        res.hw_ready      = !b_fault && mok;
        res.error_code    = err;
        res.drop_enable   = drop;
        res.warning_rise  = wrise;
    end

endmodule

### hdl/ds402_drive_enable_sequencer.sv
// Top level of the drive enable sequencer: stream ports, input and result
// registers, sequencer state. Depends on ddes_pkg, ddes_cfg and ddes_step.
//
// The block takes one drive status word per clock and returns one result beat
// for each. A beat accepted into the input register is evaluated from there
// and its result is captured in the result register before it appears on the
// master side; the sustained rate is one beat per cycle, and it slows only
// while the master side stalls. The sequencer state advances as each beat
// moves from the input register into the result register. The timeout limit
// is written through the APB port; the user must write it only while no beat
// is in flight, as the block itself does not enforce this.
module ds402_drive_enable_sequencer
    import ddes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Slave stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // s_tdata: status_word[15:0], master_ok[16], enable_cmd[17],
    //          error_reset[18], zero[23:19]
    input  logic [IN_W-1:0]   s_tdata,
    // Master stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // m_tdata: control_word[7:0], state_code[10:8], drive_enabled[11],
    //          hw_ready[12], error_code[14:13], drop_enable[15],
    //          warning_rise[16], zero[23:17]
    output logic [OUT_W-1:0]  m_tdata,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic        in_valid_reg;
    ddes_in_t    in_reg;
    logic        out_valid_reg;
    ddes_res_t   out_reg;
    ddes_ctx_t   ctx_reg;
    ddes_ctx_t   ctx_next;
    ddes_res_t   res;
    logic [15:0] timeout_cycles;
    logic        adv;
    logic        in_take;

    ddes_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .timeout_cycles (timeout_cycles)
    );

    ddes_step u_step (
        .in_beat        (in_reg),
        .ctx            (ctx_reg),
        .timeout_cycles (timeout_cycles),
        .ctx_next       (ctx_next),
        .res            (res)
    );

    // Handshake: the input register moves on when the result slot frees up
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.warning_rise, out_reg.drop_enable, out_reg.error_code,
                       out_reg.hw_ready, out_reg.drive_enabled, out_reg.state_code,
                       out_reg.control_word};

    // Valid flags and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            ctx_reg.state         <= ST_RESET;
            ctx_reg.wait_cnt      <= '0;
            ctx_reg.last_ctrl     <= CW_OFF;
            ctx_reg.warn_prev     <= 1'b0;
            ctx_reg.en_prev       <= 1'b0;
            ctx_reg.startup_done  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
                ctx_reg       <= ctx_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.status_word <= s_tdata[15:0];
            in_reg.master_ok   <= s_tdata[16];
            in_reg.enable_cmd  <= s_tdata[17];
            in_reg.error_reset <= s_tdata[18];
        end
        if (adv)
        begin
            out_reg <= res;
        end
    end

    // The sequencer state is always exactly one-hot
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(ctx_reg.state))
        else $error("sequencer state is not one-hot");

    // The startup fault clear runs once and stays done
    a_startup_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.startup_done |=> ctx_reg.startup_done)
        else $error("startup clear flag fell");

    // A timeout beat holds the control word
    a_timeout_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res.error_code == ERR_TIMEOUT) |=>
        (ctx_reg.last_ctrl == $past(ctx_reg.last_ctrl)))
        else $error("control word changed on a timeout beat");

    // A fault result reports the fault state with the drive switched off
    a_fault_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.error_code == ERR_FAULT) |->
        (out_reg.state_code == CODE_FAULT && out_reg.control_word == CW_OFF
         && out_reg.drop_enable))
        else $error("fault result is inconsistent");

    // An empty pipeline always accepts
    a_accept_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");

endmodule

### sim/tb_ds402_drive_enable_sequencer.sv
// Self-checking testbench for the drive enable sequencer: a directed table of status beats,
// then random drive behavior over several timeout limits, scored by table values or a local predictor.
// Depends on ddes_pkg and ds402_drive_enable_sequencer.
module tb_ds402_drive_enable_sequencer;
    import ddes_pkg::*;

    localparam int N_DIRECTED       = 25;
    localparam int BEATS_PER_PHASE  = 225;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int KEEP             = -1;
    localparam logic [ADDR_W-1:0] TIMEOUT_ADDR = ADDR_W'({REG_TIMEOUT, 2'b00});
    localparam ddes_res_t NO_RESULT = '0;

    // One row of the directed table; set_limit is KEEP or a new timeout limit
    typedef struct {
        int        set_limit;
        ddes_in_t  beat;
        bit        typed;
        ddes_res_t want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predicted sequencer state and its timeout limit
    logic [2:0]       seq_code      = CODE_RESET;
    logic [CNT_W-1:0] seq_wait      = '0;
    logic [7:0]       seq_ctrl      = CW_OFF;
    logic             seq_warn_prev = 1'b0;
    logic             seq_en_prev   = 1'b0;
    logic             seq_boot_done = 1'b0;
    logic [15:0]      seq_limit     = TIMEOUT_RST;

    ddes_res_t results_due[$];
    ddes_res_t got_res;
    ddes_res_t want_res;
    logic      drive_warn = 1'b0;

    int mismatches     = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int timeouts_seen  = 0;
    int faults_seen    = 0;
    int rises_seen     = 0;
    int limits_used    = 0;
    int cycles         = 0;
    int send_run_left  = 0;
    bit send_calm      = 1'b0;
    int recv_run_left  = 0;
    bit recv_calm      = 1'b0;

    // Directed rows: reset exit, startup fault clear, the full power-up ladder,
    // faults from several states, extremes of the status word and a timeout.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{KEEP, '{16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{CW_FAULT_RESET, CODE_IDLE, 1'b0, 1'b0, ERR_NONE, 1'b1, 1'b0}},
        '{KEEP, '{16'h0000, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0000, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0001, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0008, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0008, 1'b0, 1'b1, 1'b0}, 1'b1,
          '{CW_OFF, CODE_FAULT, 1'b0, 1'b0, ERR_FAULT, 1'b1, 1'b0}},
        '{KEEP, '{16'h0000, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{CW_FAULT_RESET, CODE_IDLE, 1'b0, 1'b1, ERR_NONE, 1'b1, 1'b0}},
        '{KEEP, '{16'h0080, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0080, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0001, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0003, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0007, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0007, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h000F, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h000F, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'hFFFF, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{CW_FAULT_RESET, CODE_RESET, 1'b1, 1'b0, ERR_NONE, 1'b0, 1'b1}},
        '{KEEP, '{16'h0000, 1'b1, 1'b1, 1'b1}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0000, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0000, 1'b1, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{0,    '{16'h0000, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0000, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0000, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0000, 1'b1, 1'b1, 1'b0}, 1'b1,
          '{CW_SHUTDOWN, CODE_FAULT, 1'b0, 1'b1, ERR_TIMEOUT, 1'b0, 1'b0}},
        '{KEEP, '{16'h0000, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{KEEP, '{16'h0000, 1'b1, 1'b1, 1'b1}, 1'b0, NO_RESULT}
    };

    ds402_drive_enable_sequencer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Idle cycles before the next beat, with runs of back-to-back beats mixed in.
    function automatic int draw_gap(inout int run_left, inout bit calm);
        if (run_left == 0)
        begin
            calm     = chance(30);
            run_left = $urandom_range(5, 40);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // Advance the predicted sequencer by one status beat and return its result.
    function automatic ddes_res_t advance_sequencer(input ddes_in_t b);
        ddes_res_t  r;
        logic       en;
        logic       f_ready;
        logic       f_swon;
        logic       f_open;
        logic       f_fault;
        logic       f_warn;
        logic [1:0] err;
        logic       drop;
        logic       wrise;
        en      = b.enable_cmd;
        f_ready = b.status_word[SW_READY];
        f_swon  = b.status_word[SW_SWON];
        f_open  = b.status_word[SW_OPEN];
        f_fault = b.status_word[SW_FAULT];
        f_warn  = b.status_word[SW_WARN];
        err     = ERR_NONE;
        drop    = 1'b0;
        wrise   = 1'b0;

        // Error reset is applied before anything else.
        if (b.error_reset && seq_code == CODE_FAULT)
        begin
            seq_code = CODE_RESET;
            seq_wait = '0;
        end

        if (seq_wait > {1'b0, seq_limit})
        begin
            // Timeout: latch fault, hold everything else.
            seq_code = CODE_FAULT;
            err      = ERR_TIMEOUT;
        end
        else
        begin
            if (seq_wait != CNT_MAX)
                seq_wait = seq_wait + 1'b1;

            // One-time fault clear while the bus is healthy, done once the drive reports no fault.
            if (!seq_boot_done && b.master_ok)
            begin
                if (seq_code == CODE_FAULT)
                begin
                    seq_code = CODE_RESET;
                    seq_wait = '0;
                end
                if (!f_fault)
                begin
                    seq_boot_done = 1'b1;
                    seq_code      = CODE_RESET;
                end
            end

            wrise         = f_warn && !seq_warn_prev;
            seq_warn_prev = f_warn;

            // Later checks in a state override earlier ones.
            case (seq_code)
                CODE_IDLE:
                begin
                    seq_ctrl = CW_OFF;
                    seq_wait = '0;
                    if (en && !seq_en_prev)
                        seq_code = CODE_STARTUP;
                end
                CODE_STARTUP:
                begin
                    seq_ctrl = CW_FAULT_RESET;
                    seq_wait = '0;
                    seq_code = CODE_SODIS;
                end
                CODE_SODIS:
                begin
                    seq_ctrl = CW_SHUTDOWN;
                    if (f_ready)
                    begin
                        seq_wait = '0;
                        seq_code = CODE_READY;
                    end
                    if (!en)
                        seq_code = CODE_IDLE;
                end
                CODE_READY:
                begin
                    seq_ctrl = CW_SWITCH_ON;
                    if (f_fault)
                    begin
                        seq_wait = '0;
                        seq_code = CODE_FAULT;
                    end
                    if (f_swon)
                    begin
                        seq_wait = '0;
                        seq_code = CODE_SWON;
                    end
                    if (!en)
                        seq_code = CODE_IDLE;
                end
                CODE_SWON:
                begin
                    seq_ctrl = CW_ENABLE_OP;
                    if (f_fault)
                    begin
                        seq_wait = '0;
                        seq_code = CODE_FAULT;
                    end
                    if (f_open)
                    begin
                        seq_wait = '0;
                        seq_code = CODE_OPEN;
                    end
                    if (!en)
                        seq_code = CODE_IDLE;
                end
                CODE_OPEN:
                begin
                    // Control word is held from the previous beat.
                    if (f_fault)
                        seq_code = CODE_FAULT;
                    seq_wait = '0;
                    if (!en)
                        seq_code = CODE_IDLE;
                end
                CODE_FAULT:
                begin
                    seq_ctrl = CW_OFF;
                    seq_wait = '0;
                    en       = 1'b0;
                    drop     = 1'b1;
                    err      = ERR_FAULT;
                end
                default:
                begin
                    seq_ctrl = CW_FAULT_RESET;
                    seq_wait = '0;
                    if (!f_fault)
                    begin
                        seq_code = CODE_IDLE;
                        drop     = 1'b1;
                    end
                end
            endcase
            seq_en_prev = en;
        end

        r.control_word  = seq_ctrl;
        r.state_code    = seq_code;
        r.drive_enabled = f_open;
        r.hw_ready      = !f_fault && b.master_ok;
        r.error_code    = err;
        r.drop_enable   = drop;
        r.warning_rise  = wrise;
        return r;
    endfunction

    // Random status beat: mostly a drive that answers the control word it was
    // last sent, with occasional faults, warnings and resets; the rest is noise.
    function automatic ddes_in_t draw_beat();
        ddes_in_t   b;
        logic [2:0] answer;
        if (chance(12))
        begin
            b = ddes_in_t'(19'($urandom));
            return b;
        end
        case (seq_ctrl)
            CW_SHUTDOWN:  answer = chance(70) ? 3'b001 : 3'b000;
            CW_SWITCH_ON: answer = chance(70) ? 3'b011 : 3'b001;
            CW_ENABLE_OP: answer = chance(80) ? 3'b111 : 3'b011;
            default:      answer = 3'b000;
        endcase
        if (chance(8))
            drive_warn = ~drive_warn;
        b.status_word           = 16'($urandom);
        b.status_word[2:0]      = answer;
        b.status_word[SW_FAULT] = chance(4);
        b.status_word[SW_WARN]  = drive_warn;
        b.master_ok             = chance(96);
        b.enable_cmd            = chance(93);
        b.error_reset           = (seq_code == CODE_FAULT) ? chance(40) : chance(3);
        return b;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    // Send one status beat and record the result it should produce.
    task automatic push_beat(input ddes_in_t b, input bit typed, input ddes_res_t want);
        ddes_res_t predicted;
        int        gap;
        gap = draw_gap(send_run_left, send_calm);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, b.error_reset, b.enable_cmd, b.master_ok, b.status_word};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = advance_sequencer(b);
        results_due.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // Stop sending and let every outstanding result come out.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the timeout limit while the block is idle, then read it back.
    task automatic program_limit(input logic [15:0] value);
        drain_results();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {16'h0000, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[15:0] !== value)
            flag_mismatch($sformatf("timeout limit read back %0h, wrote %0h",
                                    prdata[15:0], value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        seq_limit = value;
        limits_used++;
    endtask

    // Result side: random stalls, with runs of constant readiness.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(recv_run_left, recv_calm);
            repeat (gap)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Score every result beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res.control_word  = m_tdata[7:0];
            got_res.state_code    = m_tdata[10:8];
            got_res.drive_enabled = m_tdata[11];
            got_res.hw_ready      = m_tdata[12];
            got_res.error_code    = m_tdata[14:13];
            got_res.drop_enable   = m_tdata[15];
            got_res.warning_rise  = m_tdata[16];
            results_seen++;
            if (got_res.error_code == ERR_TIMEOUT)
                timeouts_seen++;
            if (got_res.error_code == ERR_FAULT)
                faults_seen++;
            if (got_res.warning_rise)
                rises_seen++;
            if (results_due.size() == 0)
                flag_mismatch($sformatf("result %0d arrived with none expected (data %h)",
                                        results_seen, m_tdata));
            else
            begin
                want_res = results_due.pop_front();
                if (got_res.control_word  !== want_res.control_word  ||
                    got_res.state_code    !== want_res.state_code    ||
                    got_res.drive_enabled !== want_res.drive_enabled ||
                    got_res.hw_ready      !== want_res.hw_ready      ||
                    got_res.error_code    !== want_res.error_code    ||
                    got_res.drop_enable   !== want_res.drop_enable   ||
                    got_res.warning_rise  !== want_res.warning_rise)
                    flag_mismatch($sformatf({"result %0d: expected cw=%0d st=%0d en=%b rdy=%b ",
                        "err=%0d drop=%b wr=%b, got cw=%0d st=%0d en=%b rdy=%b err=%0d ",
                        "drop=%b wr=%b"}, results_seen,
                        want_res.control_word, want_res.state_code, want_res.drive_enabled,
                        want_res.hw_ready, want_res.error_code, want_res.drop_enable,
                        want_res.warning_rise, got_res.control_word, got_res.state_code,
                        got_res.drive_enabled, got_res.hw_ready, got_res.error_code,
                        got_res.drop_enable, got_res.warning_rise));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run exceeded %0d cycles with %0d results outstanding.",
                     CYCLE_LIMIT, results_due.size());
            $display("ds402_drive_enable_sequencer test failed");
            $finish;
        end
    end

    // Main stimulus: reset, directed table, then random phases per timeout limit.
    initial
    begin
        logic [15:0] limit_plan [6];
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        limit_plan = '{16'hFFFF, 16'd0, 16'd3, TIMEOUT_RST, 16'd1, 16'd0};
        limit_plan[5] = 16'($urandom_range(2, 12));
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].set_limit != KEEP)
                program_limit(16'(directed_rows[i].set_limit));
            push_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        end

        foreach (limit_plan[p])
        begin
            program_limit(limit_plan[p]);
            repeat (BEATS_PER_PHASE) push_beat(draw_beat(), 1'b0, NO_RESULT);
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("Sent %0d status beats under %0d timeout settings; %0d results scored.",
                 beats_sent, limits_used, results_seen);
        $display("Results held %0d timeouts, %0d fault-state beats, %0d warning rises.",
                 timeouts_seen, faults_seen, rises_seen);
        if (mismatches == 0 && results_due.size() == 0)
            $display("ds402_drive_enable_sequencer test passed");
        else
            $display("ds402_drive_enable_sequencer test failed");
        $finish;
    end

endmodule
